>>> rtl/core/mst_pkg.sv
package mst_pkg;

  localparam int COORD_BITS      = 13;
  localparam int MAX_CLIENTS_DEF = 32;
  localparam int FRAC_BITS       = 8;
  localparam int NM_BITS         = 3;
  localparam int NCLI_BITS       = 6;
  localparam int IDX_OUT_BITS    = 5;
  localparam int CFG_IDX_BITS    = 3;

  localparam logic [1:0] MODE_HORZ = 2'd0;
  localparam logic [1:0] MODE_VERT = 2'd1;
  localparam logic [1:0] MODE_MAX  = 2'd2;

  localparam logic KIND_ARRANGE = 1'b0;
  localparam logic KIND_HIT     = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_LAYOUT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MASTERS  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRACTION = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIENTS  = 3'd5;

  localparam logic [NM_BITS-1:0]   MASTERS_MAX  = 3'd4;
  localparam logic [NM_BITS-1:0]   MASTERS_RST  = 3'd1;
  localparam logic [FRAC_BITS-1:0] FRACTION_MIN = 8'd3;
  localparam logic [FRAC_BITS-1:0] FRACTION_MAX = 8'd253;
  localparam logic [FRAC_BITS-1:0] FRACTION_RST = 8'd141;

  typedef struct packed {
    logic start_arr;
    logic load_ms;
    logic div_start;
    logic rect_load;
    logic step;
    logic start_hit;
    logic hit_read;
    logic hit_load;
    logic miss_load;
  } cmd_t;

  typedef struct packed {
    logic n_done;
    logic full_mode;
    logic div_done;
    logic hit_match;
    logic hit_last;
    logic count_zero;
  } status_t;

endpackage

>>> rtl/core/mst_div.sv
module mst_div #(
  parameter int DIVISOR_W = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mst_pkg::COORD_BITS-1:0] dividend,
  input  logic [DIVISOR_W-1:0]           divisor,
  output logic                           done,
  output logic [mst_pkg::COORD_BITS-1:0] quotient
);
  import mst_pkg::*;

  localparam int CNT_W = $clog2(COORD_BITS + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [COORD_BITS-1:0] quot;
  logic [DIVISOR_W:0]    shifted;
  logic                  ge;

  assign shifted  = {rem, quot[COORD_BITS-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign quotient = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(COORD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (ge) begin
        rem <= DIVISOR_W'(shifted - {1'b0, divisor});
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
      end
      quot <= {quot[COORD_BITS-2:0], ge};
    end
  end

endmodule

>>> rtl/core/mst_dp.sv
module mst_dp #(
  parameter int MAX_CLIENTS = mst_pkg::MAX_CLIENTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mst_pkg::cmd_t                        cmd,
  output mst_pkg::status_t                     status,
  input  logic                                 cfg_we,
  input  logic [mst_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mst_pkg::COORD_BITS-1:0]       cfg_data,
  input  logic [mst_pkg::COORD_BITS-1:0]       in_qx,
  input  logic [mst_pkg::COORD_BITS-1:0]       in_qy,
  output logic [mst_pkg::COORD_BITS-1:0]       rect_x,
  output logic [mst_pkg::COORD_BITS-1:0]       rect_y,
  output logic [mst_pkg::COORD_BITS-1:0]       rect_w,
  output logic [mst_pkg::COORD_BITS-1:0]       rect_h,
  output logic [mst_pkg::IDX_OUT_BITS-1:0]     client_index,
  output logic                                 found,
  output logic                                 last
);
  import mst_pkg::*;

  localparam int CNT_W  = $clog2(MAX_CLIENTS + 1);
  localparam int IDX_W  = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int RECT_W = 4 * COORD_BITS;
  localparam int CMP_W  = 8;

  // configuration registers
  logic [1:0]            layout_mode;
  logic [COORD_BITS-1:0] area_width;
  logic [COORD_BITS-1:0] area_height;
  logic [NM_BITS-1:0]    master_count;
  logic [FRAC_BITS-1:0]  master_fraction;
  logic [NCLI_BITS-1:0]  client_count;

  logic [NM_BITS-1:0]    v_nm;
  logic [FRAC_BITS-1:0]  v_frac;
  logic [NCLI_BITS-1:0]  v_cli;

  // arrange snapshot and working registers
  logic [1:0]            mode_s;
  logic [COORD_BITS-1:0] ww_s;
  logic [COORD_BITS-1:0] wh_s;
  logic [NM_BITS-1:0]    nm_s;
  logic [FRAC_BITS-1:0]  frac_s;
  logic [CNT_W-1:0]      n_s;
  logic [COORD_BITS-1:0] ms;
  logic [COORD_BITS-1:0] ma;
  logic [COORD_BITS-1:0] sa;
  logic [CNT_W-1:0]      i;
  logic [CNT_W-1:0]      acount;
  logic [COORD_BITS-1:0] qx;
  logic [COORD_BITS-1:0] qy;

  logic [RECT_W-1:0]     mem [MAX_CLIENTS];
  logic [RECT_W-1:0]     rd_data;

  logic                  horz;
  logic                  is_master;
  logic [CMP_W-1:0]      mmin;
  logic [CMP_W-1:0]      div_raw;
  logic [CNT_W-1:0]      divisor;
  logic [COORD_BITS-1:0] dividend;
  logic [COORD_BITS-1:0] size_sel;
  logic [COORD_BITS+FRAC_BITS-1:0] prod;
  logic                  div_done;
  logic [COORD_BITS-1:0] quo;
  logic [COORD_BITS-1:0] nx, ny, nw, nh;
  logic [COORD_BITS-1:0] rx, ry, rw, rh;
  logic [CNT_W:0]        i_inc;

  assign v_nm   = (cfg_data[NM_BITS-1:0] > MASTERS_MAX) ? MASTERS_MAX : cfg_data[NM_BITS-1:0];
  assign v_frac = (cfg_data[FRAC_BITS-1:0] < FRACTION_MIN) ? FRACTION_MIN :
                  (cfg_data[FRAC_BITS-1:0] > FRACTION_MAX) ? FRACTION_MAX :
                  cfg_data[FRAC_BITS-1:0];
  assign v_cli  = ({1'b0, cfg_data[NCLI_BITS-1:0]} > (NCLI_BITS+1)'(MAX_CLIENTS)) ?
                  NCLI_BITS'(MAX_CLIENTS) : cfg_data[NCLI_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode     <= MODE_HORZ;
      area_width      <= '0;
      area_height     <= '0;
      master_count    <= MASTERS_RST;
      master_fraction <= FRACTION_RST;
      client_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYOUT:   layout_mode     <= cfg_data[1:0];
        REG_WIDTH:    area_width      <= cfg_data;
        REG_HEIGHT:   area_height     <= cfg_data;
        REG_MASTERS:  master_count    <= v_nm;
        REG_FRACTION: master_fraction <= v_frac;
        REG_CLIENTS:  client_count    <= v_cli;
        default: ;
      endcase
    end
  end

  assign horz      = (mode_s == MODE_HORZ);
  assign is_master = CMP_W'(i) < CMP_W'(nm_s);
  assign mmin      = (CMP_W'(n_s) < CMP_W'(nm_s)) ? CMP_W'(n_s) : CMP_W'(nm_s);
  assign div_raw   = is_master ? (mmin - CMP_W'(i)) : (CMP_W'(n_s) - CMP_W'(i));
  assign divisor   = CNT_W'(div_raw);
  assign dividend  = (horz ? wh_s : ww_s) - (is_master ? ma : sa);
  assign size_sel  = horz ? ww_s : wh_s;
  assign prod      = size_sel * frac_s;
  assign i_inc     = {1'b0, i} + (CNT_W+1)'(1);

  mst_div #(
    .DIVISOR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  // rectangle for the current client
  always_comb begin
    nx = '0;
    ny = '0;
    nw = ww_s;
    nh = wh_s;
    if (!mode_s[1]) begin
      if (horz) begin
        nx = is_master ? '0 : ms;
        ny = is_master ? ma : sa;
        nw = is_master ? ms : (ww_s - ms);
        nh = quo;
      end else begin
        nx = is_master ? ma : sa;
        ny = is_master ? '0 : ms;
        nw = quo;
        nh = is_master ? ms : (wh_s - ms);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acount <= '0;
      i      <= '0;
    end else begin
      if (cmd.start_arr) begin
        acount <= CNT_W'(client_count);
        i      <= '0;
      end else if (cmd.start_hit) begin
        i <= '0;
      end else if (cmd.step) begin
        i <= i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_arr) begin
      mode_s <= layout_mode;
      ww_s   <= area_width;
      wh_s   <= area_height;
      nm_s   <= master_count;
      frac_s <= master_fraction;
      n_s    <= CNT_W'(client_count);
      ma     <= '0;
      sa     <= '0;
    end
    if (cmd.load_ms) begin
      if (CMP_W'(n_s) > CMP_W'(nm_s)) begin
        ms <= (nm_s != '0) ? prod[COORD_BITS+FRAC_BITS-1:FRAC_BITS] : '0;
      end else begin
        ms <= size_sel;
      end
    end
    if (cmd.rect_load && !mode_s[1]) begin
      if (is_master) begin
        ma <= ma + quo;
      end else begin
        sa <= sa + quo;
      end
    end
    if (cmd.start_hit) begin
      qx <= in_qx;
      qy <= in_qy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rect_load) begin
      mem[i[IDX_W-1:0]] <= {nh, nw, ny, nx};
    end
    if (cmd.hit_read) begin
      rd_data <= mem[i[IDX_W-1:0]];
    end
  end

  assign rx = rd_data[COORD_BITS-1:0];
  assign ry = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rw = rd_data[3*COORD_BITS-1:2*COORD_BITS];
  assign rh = rd_data[4*COORD_BITS-1:3*COORD_BITS];

  always_ff @(posedge clk) begin
    if (cmd.rect_load) begin
      rect_x       <= nx;
      rect_y       <= ny;
      rect_w       <= nw;
      rect_h       <= nh;
      client_index <= IDX_OUT_BITS'(i);
      found        <= 1'b0;
      last         <= (i_inc == {1'b0, n_s});
    end else if (cmd.hit_load || cmd.miss_load) begin
      rect_x       <= '0;
      rect_y       <= '0;
      rect_w       <= '0;
      rect_h       <= '0;
      client_index <= cmd.hit_load ? IDX_OUT_BITS'(i) : '0;
      found        <= cmd.hit_load;
      last         <= 1'b1;
    end
  end

  assign status.n_done     = (i == n_s);
  assign status.full_mode  = mode_s[1];
  assign status.div_done   = div_done;
  assign status.hit_match  = (qx >= rx) && ({1'b0, qx} < ({1'b0, rx} + {1'b0, rw})) &&
                             (qy >= ry) && ({1'b0, qy} < ({1'b0, ry} + {1'b0, rh}));
  assign status.hit_last   = (i_inc == {1'b0, acount});
  assign status.count_zero = (acount == '0);

endmodule

>>> rtl/core/mst_ctrl.sv
module mst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_kind,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mst_pkg::cmd_t    cmd,
  input  mst_pkg::status_t status
);
  import mst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_HRD   = 3'd5;
  localparam logic [2:0] S_HCMP  = 3'd6;
  localparam logic [2:0] S_HEMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT) || (state == S_HEMIT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_HIT) begin
            cmd.start_hit = 1'b1;
            if (status.count_zero) begin
              cmd.miss_load = 1'b1;
              state_next    = S_HEMIT;
            end else begin
              state_next = S_HRD;
            end
          end else begin
            cmd.start_arr = 1'b1;
            state_next    = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.load_ms = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        priority if (status.n_done) begin
          state_next = S_IDLE;
        end else if (status.full_mode) begin
          cmd.rect_load = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.rect_load = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.step   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_HRD: begin
        cmd.hit_read = 1'b1;
        state_next   = S_HCMP;
      end
      S_HCMP: begin
        priority if (status.hit_match) begin
          cmd.hit_load = 1'b1;
          state_next   = S_HEMIT;
        end else if (status.hit_last) begin
          cmd.miss_load = 1'b1;
          state_next    = S_HEMIT;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_HRD;
        end
      end
      S_HEMIT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_load_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.rect_load |=> out_valid)
    else $error("rectangle loaded without being offered");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.full_mode && !status.n_done)
    else $error("divide started with nothing to divide");

endmodule

>>> rtl/core/master_stack_tiler.sv
// Arrange: setup in S_IDLE and S_MUL, then per client a check state, the divider
// (one quotient bit a cycle) and an output state held until taken; max mode skips the divider.
// Hit test: stored rectangles are read via the table's read port and compared, then 1 result.
// One transaction is worked at a time; the next is taken once the last result is delivered.
// Reset (synchronous, rst high) restores register defaults and empties the stored table
// count; table contents are not cleared, entries beyond the count are never read.
module master_stack_tiler #(
  parameter int MAX_CLIENTS = mst_pkg::MAX_CLIENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,   // query_x, query_y
  input  logic                             s_tuser,   // kind
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [63:0]                      m_tdata,   // rect_x, rect_y, rect_w, rect_h,
                                                      // client_index, found
  output logic                             m_tlast,
  input  logic                             cfg_we,
  input  logic [mst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mst_pkg::COORD_BITS-1:0]   cfg_data
);
  import mst_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic [COORD_BITS-1:0]   rect_x, rect_y, rect_w, rect_h;
  logic [IDX_OUT_BITS-1:0] client_index;
  logic                    found;

  mst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  mst_dp #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_qx        (s_tdata[COORD_BITS-1:0]),
    .in_qy        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .rect_x       (rect_x),
    .rect_y       (rect_y),
    .rect_w       (rect_w),
    .rect_h       (rect_h),
    .client_index (client_index),
    .found        (found),
    .last         (m_tlast)
  );

  assign m_tdata = {6'd0, found, client_index, rect_h, rect_w, rect_y, rect_x};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mst_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_CAP  = 1000000;
  localparam int MAX_CLI    = 32;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 3'd7;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t                  x;
    coord_t                  y;
    coord_t                  w;
    coord_t                  h;
    logic [IDX_OUT_BITS-1:0] idx;
    logic                    found;
    logic                    last;
  } tile_t;

  class tile_scoreboard;
    logic [1:0]           mode;
    coord_t               area_w;
    coord_t               area_h;
    logic [NM_BITS-1:0]   masters;
    logic [FRAC_BITS-1:0] frac;
    logic [NCLI_BITS-1:0] clients;
    tile_t                layout[MAX_CLI];
    int unsigned          placed;
    tile_t                due[$];
    int                   errors;
    int                   rect_seen;
    int                   hits_seen;
    int                   found_seen;

    function new();
      mode = MODE_HORZ;
      area_w = '0;
      area_h = '0;
      masters = MASTERS_RST;
      frac = FRACTION_RST;
      clients = '0;
      placed = 0;
      errors = 0;
      rect_seen = 0;
      hits_seen = 0;
      found_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
      case (idx)
        REG_LAYOUT: mode = val[1:0];
        REG_WIDTH: area_w = val;
        REG_HEIGHT: area_h = val;
        REG_MASTERS: masters = (val[2:0] > MASTERS_MAX) ? MASTERS_MAX : val[2:0];
        REG_FRACTION: begin
          if (val[7:0] < FRACTION_MIN) frac = FRACTION_MIN;
          else if (val[7:0] > FRACTION_MAX) frac = FRACTION_MAX;
          else frac = val[7:0];
        end
        REG_CLIENTS: clients = (val[5:0] > MAX_CLI) ? NCLI_BITS'(MAX_CLI) : val[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned share(int unsigned size, int unsigned used, int unsigned left);
      return (left == 0) ? 0 : (size - used) / left;
    endfunction

    function void tile_area();
      int unsigned n, nm, mmin, ms, ma, sa, span, ext;
      n = clients;
      nm = masters;
      mmin = (n < nm) ? n : nm;
      ma = 0;
      sa = 0;
      span = (mode == MODE_HORZ) ? area_w : area_h;
      if (n > nm) ms = (nm != 0) ? ((span * frac) >> 8) : 0;
      else ms = span;
      for (int i = 0; i < n; i++) begin
        if (mode == MODE_HORZ) begin
          if (i < nm) begin
            ext = share(area_h, ma, mmin - i);
            layout[i].x = '0; layout[i].y = coord_t'(ma);
            layout[i].w = coord_t'(ms); layout[i].h = coord_t'(ext);
            ma += ext;
          end else begin
            ext = share(area_h, sa, n - i);
            layout[i].x = coord_t'(ms); layout[i].y = coord_t'(sa);
            layout[i].w = coord_t'(area_w - ms); layout[i].h = coord_t'(ext);
            sa += ext;
          end
        end else if (mode == MODE_VERT) begin
          if (i < nm) begin
            ext = share(area_w, ma, mmin - i);
            layout[i].x = coord_t'(ma); layout[i].y = '0;
            layout[i].h = coord_t'(ms); layout[i].w = coord_t'(ext);
            ma += ext;
          end else begin
            ext = share(area_w, sa, n - i);
            layout[i].x = coord_t'(sa); layout[i].y = coord_t'(ms);
            layout[i].h = coord_t'(area_h - ms); layout[i].w = coord_t'(ext);
            sa += ext;
          end
        end else begin
          layout[i].x = '0; layout[i].y = '0; layout[i].w = area_w; layout[i].h = area_h;
        end
      end
      placed = n;
    endfunction

    function void note_input(logic kind, coord_t qx, coord_t qy);
      tile_t r;
      if (kind == KIND_ARRANGE) begin
        tile_area();
        for (int i = 0; i < placed; i++) begin
          r = layout[i];
          r.idx = IDX_OUT_BITS'(i);
          r.found = 1'b0;
          r.last = (i + 1 == placed);
          due.push_back(r);
        end
      end else begin
        r = '{default: '0};
        r.last = 1'b1;
        for (int i = 0; i < placed; i++) begin
          if (qx >= layout[i].x && int'(qx) < int'(layout[i].x) + int'(layout[i].w) &&
              qy >= layout[i].y && int'(qy) < int'(layout[i].y) + int'(layout[i].h)) begin
            r.found = 1'b1;
            r.idx = IDX_OUT_BITS'(i);
            break;
          end
        end
        due.push_back(r);
      end
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    endfunction

    function void check_result(logic [63:0] d, logic l);
      tile_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected result, actual data %h last %b", $time, d, l);
        errors++;
        return;
      end
      e = due.pop_front();
      if (d[12:0] !== e.x) report("rect_x", e.x, d[12:0]);
      if (d[25:13] !== e.y) report("rect_y", e.y, d[25:13]);
      if (d[38:26] !== e.w) report("rect_w", e.w, d[38:26]);
      if (d[51:39] !== e.h) report("rect_h", e.h, d[51:39]);
      if (d[56:52] !== e.idx) report("client_index", e.idx, d[56:52]);
      if (d[57] !== e.found) report("found", e.found, d[57]);
      if (l !== e.last) report("last", e.last, l);
      if (d[57]) found_seen++;
      rect_seen++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  coord_t      cfg_data = '0;

  tile_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit rx_hold = 1'b0;
  int cycles = 0;
  int items = 0;

  master_stack_tiler i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout", $time);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: check each result, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    if (rx_hold) m_tready <= 1'b0;
    else m_tready <= !(rx_idle && $urandom_range(99) < 34);
  end

  task automatic write_regs(logic [1:0] mode, coord_t w, coord_t h, coord_t nm,
                            coord_t frac, coord_t nc);
    logic [CFG_IDX_BITS-1:0] idx[7];
    coord_t                  val[7];
    idx = '{REG_LAYOUT, REG_WIDTH, REG_HEIGHT, REG_MASTERS, REG_FRACTION, REG_CLIENTS,
            REG_SPARE};
    val = '{coord_t'(mode), w, h, nm, frac, nc, coord_t'($urandom)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(logic kind, coord_t qx, coord_t qy);
    if (tx_idle && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 34) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'd0, qy, qx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(kind, qx, qy);
    if (kind == KIND_HIT) sb.hits_seen++;
    items++;
  endtask

  // hold until every expected result is in, plus slack for result-free arranges
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic probe();
    coord_t qx, qy;
    if ($urandom_range(3) == 0) begin
      qx = coord_t'($urandom);
      qy = coord_t'($urandom);
    end else begin
      qx = coord_t'($urandom_range(int'(sb.area_w) + 2));
      qy = coord_t'($urandom_range(int'(sb.area_h) + 2));
    end
    send(KIND_HIT, qx, qy);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, clamps, every mode
    send(KIND_HIT, 13'd0, 13'd0);
    drain();
    write_regs(MODE_HORZ, 13'd8191, 13'd8191, 13'd7, 13'd255, 13'd63);
    send(KIND_ARRANGE, 13'd0, 13'd0);
    send(KIND_HIT, 13'd8191, 13'd8191);
    send(KIND_HIT, 13'd0, 13'd0);
    send(KIND_HIT, 13'd7000, 13'd100);
    drain();
    write_regs(MODE_VERT, 13'd0, 13'd500, 13'd0, 13'd0, 13'd5);
    send(KIND_ARRANGE, 13'd0, 13'd0);
    send(KIND_HIT, 13'd0, 13'd10);
    drain();
    write_regs(MODE_VERT, 13'd800, 13'd600, 13'd2, 13'd128, 13'd2);
    send(KIND_ARRANGE, 13'h1555, 13'h0aaa);
    send(KIND_HIT, 13'd400, 13'd300);
    send(KIND_HIT, 13'd399, 13'd599);
    send(KIND_HIT, 13'd800, 13'd0);
    drain();
    write_regs(2'd3, 13'd640, 13'd480, 13'd1, 13'd3, 13'd3);
    send(KIND_ARRANGE, 13'd0, 13'd0);
    send(KIND_HIT, 13'd639, 13'd479);
    drain();
    write_regs(MODE_MAX, 13'd100, 13'd100, 13'd3, 13'd200, 13'd0);
    send(KIND_ARRANGE, 13'd0, 13'd0);
    send(KIND_HIT, 13'd5, 13'd5);
    drain();
    write_regs(MODE_HORZ, 13'd1000, 13'd700, 13'd4, 13'd90, 13'd9);
    // stale table: registers change but hits use the old arrange
    send(KIND_HIT, 13'd5, 13'd5);
    send(KIND_ARRANGE, 13'd0, 13'd0);
    send(KIND_HIT, 13'd999, 13'd699);
    drain();

    // back-pressure: stall results while arranges keep coming
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
      begin
        repeat (6) send(KIND_ARRANGE, 13'd0, 13'd0);
      end
    join
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      coord_t nc;
      tx_idle = (ph != 5 && ph != 6);
      rx_idle = tx_idle;
      nc = ($urandom_range(5) == 0) ? coord_t'($urandom_range(63)) :
                                      coord_t'($urandom_range(8));
      write_regs(2'($urandom_range(3)), coord_t'($urandom), coord_t'($urandom),
                 coord_t'($urandom_range(7)), coord_t'($urandom_range(255)), nc);
      for (int k = 0; k < 25; k++) begin
        if ($urandom_range(99) < 35) send(KIND_ARRANGE, coord_t'($urandom), coord_t'($urandom));
        else probe();
      end
      drain();
    end

    repeat (32) @(posedge clk);
    $display("ran %0d transactions in, %0d results checked (%0d hit tests, %0d found)",
             items, sb.rect_seen, sb.hits_seen, sb.found_seen);
    $display("covered all layout modes, register clamps, empty arranges and result stalls");
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
